// ===== hdl/prmmd_pkg.sv =====
// ----------------------------------------------------------------------------
// prmmd_pkg
// Types and constants shared by the paged ROM memory map decoder and its
// checker: request and response layouts, target codes, register indexes.
// ----------------------------------------------------------------------------
package prmmd_pkg;

  localparam logic [4:0]  BANK_COUNT    = 5'd16;
  localparam logic [15:0] ADDR_BANK_SEL = 16'hfe30;
  localparam logic [15:0] ADDR_EXIT     = 16'hfc01;
  localparam logic [7:0]  FIXED_VALUE   = 8'hfe;
  localparam logic [15:0] MASK_RESET    = 16'hffff;
  localparam logic [3:0]  BANK_RESET    = 4'd15;

  typedef enum logic [3:0] {
    TGT_RAM   = 4'd0,
    TGT_BANK  = 4'd1,
    TGT_OS    = 4'd2,
    TGT_SVIA  = 4'd3,
    TGT_UVIA  = 4'd4,
    TGT_CRTC  = 4'd5,
    TGT_ULA   = 4'd6,
    TGT_DISC  = 4'd7,
    TGT_ADC   = 4'd8,
    TGT_FIXED = 4'd9,
    TGT_NONE  = 4'd10
  } target_t;

  typedef enum logic {
    CMD_READ  = 1'b0,
    CMD_WRITE = 1'b1
  } command_t;

  typedef enum logic {
    CFG_ALL_WRITABLE = 1'b0,
    CFG_WRITE_MASK   = 1'b1
  } cfg_index_t;

  typedef struct packed {
    logic        command;
    logic [15:0] address;
    logic [7:0]  write_data;
  } prmmd_req_t;

  typedef struct packed {
    logic [3:0]  target;
    logic [3:0]  device_offset;
    logic [17:0] mem_address;
    logic        mem_write;
    logic [7:0]  fixed_data;
    logic [1:0]  extra_cycles;
    logic        halt_request;
    logic        bank_writeback;
    logic [3:0]  current_bank;
    logic        sideways_ram_dirty;
  } prmmd_resp_t;

endpackage

// ===== hdl/paged_rom_memory_map_decoder.sv =====
// ----------------------------------------------------------------------------
// paged_rom_memory_map_decoder
// Decodes one bus access per request into its target, physical address,
// write permission and stretch cycles; tracks the selected sideways bank.
// ----------------------------------------------------------------------------
// Path: an accepted request is held in the input register, then its response in
// the response register, which drives out_valid.
// Throughput: one request per cycle while the response side is not stalled.
// Reset: synchronous, active low; bank 15 selected, flags and stretch
// counters cleared, every bank writable by mask, pipeline empty.
module paged_rom_memory_map_decoder (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  prmmd_pkg::prmmd_req_t     in_req,
  output logic                      out_valid,
  input  logic                      out_stall,
  output prmmd_pkg::prmmd_resp_t    out_resp,
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [15:0]               cfg_data
);
  import prmmd_pkg::*;

  logic        s1_valid_r;
  prmmd_req_t  s1_req_r;
  logic        out_valid_r;
  prmmd_resp_t out_resp_r;
  prmmd_resp_t resp_nxt;

  logic        all_wr_r;
  logic [15:0] wr_mask_r;
  logic [3:0]  bank_r, bank_nxt;
  logic        bank_mod_r, bank_mod_nxt;
  logic        ram_mod_r, ram_mod_nxt;
  logic [3:0]  rd_cnt_r, rd_cnt_nxt;
  logic [3:0]  wr_cnt_r, wr_cnt_nxt;

  logic        s2_ready;
  logic        s1_fire;

  assign s2_ready  = !out_valid_r || !out_stall;
  assign s1_fire   = s1_valid_r && s2_ready;
  assign in_stall  = s1_valid_r && !s2_ready;
  assign out_valid = out_valid_r;
  assign out_resp  = out_resp_r;

  always_comb begin
    logic [15:0] a;
    logic [15:0] blk16;
    logic        present;
    logic        is_ram;
    a        = s1_req_r.address;
    blk16    = a & 16'hfff0;
    present  = {1'b0, bank_r} < BANK_COUNT;
    is_ram   = wr_mask_r[bank_r];
    bank_nxt     = bank_r;
    bank_mod_nxt = bank_mod_r;
    ram_mod_nxt  = ram_mod_r;
    rd_cnt_nxt   = rd_cnt_r;
    wr_cnt_nxt   = wr_cnt_r;
    resp_nxt     = '0;
    resp_nxt.target = TGT_NONE;
    if (s1_req_r.command == CMD_READ) begin
      if (!a[15]) begin
        resp_nxt.target      = TGT_RAM;
        resp_nxt.mem_address = {2'b00, a};
      end else if (!a[14]) begin
        if (present) begin
          resp_nxt.target      = TGT_BANK;
          resp_nxt.mem_address = {bank_r, a[13:0]};
        end
      end else if (a < 16'hfc00 || a >= 16'hff00) begin
        resp_nxt.target      = TGT_OS;
        resp_nxt.mem_address = {2'b00, a};
      end else begin
        rd_cnt_nxt = rd_cnt_r + 4'd1;
        resp_nxt.extra_cycles = {rd_cnt_nxt[3], !rd_cnt_nxt[3]};
        if (blk16 inside {16'hfe40, 16'hfe50}) begin
          resp_nxt.target        = TGT_SVIA;
          resp_nxt.device_offset = a[3:0];
        end else if (blk16 inside {16'hfe60, 16'hfe70}) begin
          resp_nxt.target        = TGT_UVIA;
          resp_nxt.device_offset = a[3:0];
        end else if ((a & 16'hfff8) == 16'hfe00) begin
          resp_nxt.target        = TGT_CRTC;
          resp_nxt.device_offset = {1'b0, a[2:0]};
        end else if (blk16 == 16'hfe20) begin
          resp_nxt.target        = TGT_ULA;
          resp_nxt.device_offset = a[3:0];
        end else if ((a & 16'hffe0) == 16'hfe80) begin
          resp_nxt.target        = TGT_DISC;
          resp_nxt.device_offset = {1'b0, a[2:0]};
        end else if ((a & 16'hffe0) inside {16'hfea0, 16'hfee0}) begin
          resp_nxt.target     = TGT_FIXED;
          resp_nxt.fixed_data = FIXED_VALUE;
        end else if ((a & 16'hffe0) == 16'hfec0) begin
          resp_nxt.target        = TGT_ADC;
          resp_nxt.device_offset = a[3:0];
        end
      end
    end else begin
      if (!a[15]) begin
        resp_nxt.target      = TGT_RAM;
        resp_nxt.mem_address = {2'b00, a};
        resp_nxt.mem_write   = 1'b1;
      end else if (!a[14]) begin
        if (present) begin
          resp_nxt.target      = TGT_BANK;
          resp_nxt.mem_address = {bank_r, a[13:0]};
          if (all_wr_r || is_ram) begin
            resp_nxt.mem_write = 1'b1;
            bank_mod_nxt       = 1'b1;
            if (is_ram) begin
              ram_mod_nxt = 1'b1;
            end
          end
        end
      end else begin
        wr_cnt_nxt = wr_cnt_r + 4'd1;
        resp_nxt.extra_cycles = {wr_cnt_nxt[3], !wr_cnt_nxt[3]};
        if (a < 16'hfc00 || a >= 16'hff00) begin
          resp_nxt.target      = TGT_OS;
          resp_nxt.mem_address = {2'b00, a};
        end else if (blk16 == 16'hfe20) begin
          resp_nxt.target        = TGT_ULA;
          resp_nxt.device_offset = a[3:0];
        end else if (blk16 inside {16'hfe40, 16'hfe50}) begin
          resp_nxt.target        = TGT_SVIA;
          resp_nxt.device_offset = a[3:0];
        end else if (blk16 inside {16'hfe60, 16'hfe70}) begin
          resp_nxt.target        = TGT_UVIA;
          resp_nxt.device_offset = a[3:0];
        end else if (a == ADDR_BANK_SEL) begin
          if (s1_req_r.write_data[3:0] != bank_r) begin
            if (bank_mod_r) begin
              resp_nxt.bank_writeback = 1'b1;
              bank_mod_nxt            = 1'b0;
            end
            bank_nxt = s1_req_r.write_data[3:0];
          end
        end else if ((a & 16'hfff8) == 16'hfe00) begin
          resp_nxt.target        = TGT_CRTC;
          resp_nxt.device_offset = {1'b0, a[2:0]};
        end else if ((a & 16'hffe0) == 16'hfe80) begin
          resp_nxt.target        = TGT_DISC;
          resp_nxt.device_offset = {1'b0, a[2:0]};
        end else if ((a & 16'hffe0) == 16'hfec0) begin
          resp_nxt.target        = TGT_ADC;
          resp_nxt.device_offset = a[3:0];
        end else if (a == ADDR_EXIT) begin
          resp_nxt.halt_request = 1'b1;
        end
      end
    end
    resp_nxt.current_bank       = bank_nxt;
    resp_nxt.sideways_ram_dirty = ram_mod_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      all_wr_r    <= 1'b0;
      wr_mask_r   <= MASK_RESET;
      bank_r      <= BANK_RESET;
      bank_mod_r  <= 1'b0;
      ram_mod_r   <= 1'b0;
      rd_cnt_r    <= '0;
      wr_cnt_r    <= '0;
    end else begin
      if (!in_stall) begin
        s1_valid_r <= in_valid;
      end
      if (s2_ready) begin
        out_valid_r <= s1_valid_r;
      end
      if (s1_fire) begin
        bank_r     <= bank_nxt;
        bank_mod_r <= bank_mod_nxt;
        ram_mod_r  <= ram_mod_nxt;
        rd_cnt_r   <= rd_cnt_nxt;
        wr_cnt_r   <= wr_cnt_nxt;
      end
      if (cfg_we) begin
        case (cfg_index_t'(cfg_index))
          CFG_ALL_WRITABLE: all_wr_r  <= cfg_data[0];
          CFG_WRITE_MASK:   wr_mask_r <= cfg_data;
          default:          all_wr_r  <= all_wr_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_req_r <= in_req;
    end
    if (s1_fire) begin
      out_resp_r <= resp_nxt;
    end
  end

endmodule

// ===== hdl/prmmd_checker.sv =====
// ----------------------------------------------------------------------------
// prmmd_checker
// Port-level checks on the paged ROM memory map decoder response channel.
// ----------------------------------------------------------------------------
module prmmd_checker (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_valid,
  input logic                   out_stall,
  input prmmd_pkg::prmmd_resp_t out_resp
);
  import prmmd_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_resp))
    else $error("stalled response changed");

  a_write_target: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_resp.mem_write |->
      out_resp.target == TGT_RAM || out_resp.target == TGT_BANK)
    else $error("memory write outside RAM or bank");

  a_fixed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_resp.target == TGT_FIXED |->
      out_resp.fixed_data == FIXED_VALUE && out_resp.extra_cycles != 2'd0)
    else $error("fixed target without value or stretch");

  a_halt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_resp.halt_request |->
      out_resp.target == TGT_NONE && !out_resp.mem_write && !out_resp.bank_writeback)
    else $error("halt request on a decoded target");

  a_writeback: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_resp.bank_writeback |->
      out_resp.target == TGT_NONE && out_resp.extra_cycles != 2'd0)
    else $error("bank write-back outside bank select write");

endmodule

bind paged_rom_memory_map_decoder prmmd_checker u_prmmd_checker (.*);
